// ----- hdl/i2c_master_line_sequencer_assert.svh -----
// Assertion macros for the I2C master line sequencer.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef I2C_MASTER_LINE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_LINE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define I2CMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/i2cms_pkg.sv -----
// Shared types and constants of the I2C master line sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;
  localparam int TOUT_W   = 9;
  localparam int HOLD_W   = 8;
  localparam int BITCNT_W = 4;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_WAIT  = 3'd5;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_HOLD   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BIT_PHASE   = 2'd2;

  localparam logic [TOUT_W-1:0] ACK_TIMEOUT_RST = 9'd300;
  localparam logic [HOLD_W-1:0] EDGE_HOLD_RST   = 8'd5;
  localparam logic [HOLD_W-1:0] BIT_PHASE_RST   = 8'd2;

  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [TOUT_W-1:0] ack_timeout;
    logic [HOLD_W-1:0] edge_hold_ticks;
    logic [HOLD_W-1:0] bit_phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   tx_byte;
    logic                send_ack;
    logic                sda_in;
  } req_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_missing;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/i2cms_regs.sv -----
// APB register file holding the timeout and hold counts of the sequencer.
// Depends on i2cms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_regs import i2cms_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout     <= ACK_TIMEOUT_RST;
      cfg.edge_hold_ticks <= EDGE_HOLD_RST;
      cfg.bit_phase_ticks <= BIT_PHASE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACK_TIMEOUT: cfg.ack_timeout     <= pwdata[TOUT_W-1:0];
        REG_EDGE_HOLD:   cfg.edge_hold_ticks <= pwdata[HOLD_W-1:0];
        REG_BIT_PHASE:   cfg.bit_phase_ticks <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACK_TIMEOUT: prdata = {{(32-TOUT_W){1'b0}}, cfg.ack_timeout};
      REG_EDGE_HOLD:   prdata = {{(32-HOLD_W){1'b0}}, cfg.edge_hold_ticks};
      REG_BIT_PHASE:   prdata = {{(32-HOLD_W){1'b0}}, cfg.bit_phase_ticks};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/i2cms_step.sv -----
// Line sequencer state machine: advances one step for each tick request.
// Depends on i2cms_pkg; gives the result of the tick combinationally.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_step import i2cms_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output res_t      res
);

  typedef enum logic [3:0] {
    S_IDLE, S_START_A, S_START_B, S_STOP_A, S_STOP_B, S_STOP_C,
    S_WR_SET, S_WR_HIGH, S_WR_LOW, S_RD_SET, S_RD_HIGH, S_RD_LOW,
    S_AK_SET, S_AK_HIGH, S_WA_SET, S_WA_POLL
  } state_t;

  state_t              state, state_next;
  logic [HOLD_W-1:0]   tick_count, tick_count_next;
  logic [BITCNT_W-1:0] bit_count, bit_count_next;
  logic [BYTE_W-1:0]   shift_reg, shift_reg_next;
  logic [TOUT_W-1:0]   poll_count, poll_count_next;
  logic                ack_choice, ack_choice_next;
  logic                scl_level, scl_level_next;
  logic                sda_level, sda_level_next;
  logic [BYTE_W-1:0]   rx_held, rx_held_next;
  logic                ack_flag, ack_flag_next;
  logic                done;

  logic [HOLD_W-1:0]   hold;
  logic [HOLD_W-1:0]   tick_inc;
  logic                over;
  logic [BITCNT_W-1:0] bit_inc;

  always_comb begin
    unique case (state)
      S_START_A, S_START_B, S_STOP_A, S_STOP_B, S_STOP_C: hold = cfg.edge_hold_ticks;
      default: hold = cfg.bit_phase_ticks;
    endcase
  end

  assign tick_inc = tick_count + 1'b1;
  assign over     = (tick_inc >= hold);
  assign bit_inc  = bit_count + 1'b1;

  always_comb begin
    state_next      = state;
    tick_count_next = over ? '0 : tick_inc;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    poll_count_next = poll_count;
    ack_choice_next = ack_choice;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    rx_held_next    = rx_held;
    ack_flag_next   = ack_flag;
    done            = 1'b0;
    unique case (state)
      S_IDLE: begin
        tick_count_next = '0;
        case (req.action)
          ACT_START: begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
            state_next     = S_START_A;
          end
          ACT_STOP: begin
            sda_level_next = 1'b0;
            scl_level_next = 1'b0;
            state_next     = S_STOP_A;
          end
          ACT_WRITE: begin
            bit_count_next = '0;
            scl_level_next = 1'b0;
            sda_level_next = req.tx_byte[BYTE_W-1];
            shift_reg_next = {req.tx_byte[BYTE_W-2:0], 1'b0};
            state_next     = S_WR_SET;
          end
          ACT_READ: begin
            sda_level_next  = 1'b1;
            scl_level_next  = 1'b0;
            shift_reg_next  = '0;
            bit_count_next  = '0;
            ack_choice_next = req.send_ack;
            state_next      = S_RD_SET;
          end
          ACT_WAIT: begin
            scl_level_next  = 1'b0;
            sda_level_next  = 1'b1;
            poll_count_next = '0;
            state_next      = S_WA_SET;
          end
          default: ;
        endcase
      end
      S_START_A: if (over) begin
        sda_level_next = 1'b0;
        state_next     = S_START_B;
      end
      S_START_B: if (over) begin
        scl_level_next = 1'b0;
        state_next     = S_IDLE;
        done           = 1'b1;
      end
      S_STOP_A: if (over) begin
        scl_level_next = 1'b1;
        state_next     = S_STOP_B;
      end
      S_STOP_B: if (over) begin
        sda_level_next = 1'b1;
        state_next     = S_STOP_C;
      end
      S_STOP_C: if (over) begin
        state_next = S_IDLE;
        done       = 1'b1;
      end
      S_WR_SET: if (over) begin
        scl_level_next = 1'b1;
        state_next     = S_WR_HIGH;
      end
      S_WR_HIGH: if (over) begin
        scl_level_next = 1'b0;
        state_next     = S_WR_LOW;
      end
      S_WR_LOW: if (over) begin
        bit_count_next = bit_inc;
        if (bit_inc >= BITS_PER_BYTE) begin
          state_next = S_IDLE;
          done       = 1'b1;
        end else begin
          scl_level_next = 1'b0;
          sda_level_next = shift_reg[BYTE_W-1];
          shift_reg_next = {shift_reg[BYTE_W-2:0], 1'b0};
          state_next     = S_WR_SET;
        end
      end
      S_RD_SET: if (over) begin
        scl_level_next = 1'b1;
        shift_reg_next = {shift_reg[BYTE_W-2:0], req.sda_in};
        state_next     = S_RD_HIGH;
      end
      S_RD_HIGH: if (over) begin
        scl_level_next = 1'b0;
        state_next     = S_RD_LOW;
      end
      S_RD_LOW: if (over) begin
        bit_count_next = bit_inc;
        scl_level_next = 1'b0;
        if (bit_inc >= BITS_PER_BYTE) begin
          rx_held_next   = shift_reg;
          sda_level_next = !ack_choice;
          state_next     = S_AK_SET;
        end else begin
          state_next = S_RD_SET;
        end
      end
      S_AK_SET: if (over) begin
        scl_level_next = 1'b1;
        state_next     = S_AK_HIGH;
      end
      S_AK_HIGH: if (over) begin
        scl_level_next = 1'b0;
        state_next     = S_IDLE;
        done           = 1'b1;
      end
      S_WA_SET: begin
        tick_count_next = '0;
        scl_level_next  = 1'b1;
        state_next      = S_WA_POLL;
      end
      S_WA_POLL: begin
        tick_count_next = tick_count;
        if (!req.sda_in) begin
          scl_level_next = 1'b0;
          ack_flag_next  = 1'b0;
          state_next     = S_IDLE;
          done           = 1'b1;
        end else if (poll_count >= cfg.ack_timeout) begin
          ack_flag_next   = 1'b1;
          sda_level_next  = 1'b0;
          scl_level_next  = 1'b0;
          tick_count_next = '0;
          state_next      = S_STOP_A;
        end else begin
          poll_count_next = poll_count + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      bit_count  <= '0;
      shift_reg  <= '0;
      poll_count <= '0;
      ack_choice <= 1'b0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      rx_held    <= '0;
      ack_flag   <= 1'b0;
    end else if (en) begin
      state      <= state_next;
      tick_count <= tick_count_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      poll_count <= poll_count_next;
      ack_choice <= ack_choice_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      rx_held    <= rx_held_next;
      ack_flag   <= ack_flag_next;
    end
  end

  assign res.scl_out     = scl_level_next;
  assign res.sda_out     = sda_level_next;
  assign res.busy_res    = (state_next != S_IDLE);
  assign res.done_res    = done;
  assign res.rx_byte     = rx_held_next;
  assign res.ack_missing = ack_flag_next;

endmodule

`default_nettype wire

// ----- hdl/i2c_master_line_sequencer.sv -----
// A tick request passes the input register and then the result register; the
// block takes one tick request per cycle while the output is not stalled.
// The sequencer state advances once per request, in the cycle the request leaves
// the input register; a stalled output holds both stages.
// Reset is synchronous: lines released, sequencer idle, registers at defaults.
// Depends on i2cms_pkg, i2cms_regs, i2cms_step and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_line_sequencer_assert.svh"

module i2c_master_line_sequencer import i2cms_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero pad
  input  wire logic [2:0]  s_tuser,   // action[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // scl_out[0], sda_out[1], busy_res[2],
                                      // done_res[3], rx_byte[11:4], ack_missing[12]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  req_t in_req;
  logic in_valid;
  res_t step_res;
  res_t out_res;
  logic advance;
  logic out_free;

  i2cms_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req.action   <= s_tuser;
      in_req.tx_byte  <= s_tdata[7:0];
      in_req.send_ack <= s_tdata[8];
      in_req.sda_in   <= s_tdata[9];
    end
  end

  i2cms_step u_step (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .req (in_req),
    .cfg (cfg),
    .res (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {3'b000, out_res.ack_missing, out_res.rx_byte, out_res.done_res,
                    out_res.busy_res, out_res.sda_out, out_res.scl_out};

  `I2CMS_ASSERT_NOW(a_done_not_busy, m_tvalid && out_res.done_res, !out_res.busy_res,
    "Result marks done while still busy.")
  `I2CMS_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !in_valid, !m_tvalid,
    "Result stage did not drain with the input stage empty.")
  `I2CMS_ASSERT_NOW(a_stall_holds, !s_tready, in_valid && m_tvalid && !m_tready,
    "Input side stalled without a pending request on both stages.")

endmodule

`default_nettype wire
